FILE: design/hts_pkg.sv
// Shared types and constants of the Huffman tree stream decoder.
// No dependencies; hts_ctrl, hts_datapath and the top level refer to it by scoped names.
package hts_pkg;

	// Longest code that an insert item may carry.
	localparam int MAX_CODE_BITS = 32;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_DATA   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_CONFLICT = 2'd2,
		ST_MISSING  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		INS_DONE  = 2'd0,
		INS_READ  = 2'd1,
		INS_ALLOC = 2'd2
	} ins_out_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       has_symbol;
		logic       last;
		logic       finished;
		status_t    status;
	} res_t;

	typedef struct packed {
		logic accept;
		logic ins_step;
		logic ins_load;
		logic ins_zero;
		logic walk;
		logic fin;
	} ctl_cmd_t;

	typedef struct packed {
		func_t    func;
		logic     len_bad;
		ins_out_t ins_outcome;
		logic     walk_end;
		logic     out_free;
	} dp_status_t;

endpackage

FILE: design/hts_stream_if.sv
// Handshake interfaces for the input items and the result items.
// Uses no package; payload widths are those of the item fields.
interface hts_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  code_symbol;
	logic [5:0]  code_length;
	logic [31:0] code_bits;
	logic [7:0]  data_byte;

	modport source(output valid, func, code_symbol, code_length, code_bits, data_byte,
		input ready);
	modport sink(input valid, func, code_symbol, code_length, code_bits, data_byte,
		output ready);
endinterface

interface hts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       has_symbol;
	logic       last;
	logic       finished;
	logic [1:0] status;

	modport source(output valid, symbol, has_symbol, last, finished, status, input ready);
	modport sink(input valid, symbol, has_symbol, last, finished, status, output ready);
endinterface

FILE: design/hts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: design/hts_ctrl.sv
// Sequencer of the decoder: accepts items and steps the datapath.
// Depends on hts_pkg for the command and status structs.
module hts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hts_pkg::dp_status_t st,
	output hts_pkg::ctl_cmd_t   cmd
);
	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INS_STEP = 6'b000010,
		S_INS_READ = 6'b000100,
		S_INS_ZERO = 6'b001000,
		S_WALK     = 6'b010000,
		S_FIN      = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.accept   = in_valid && (state_q == S_IDLE);
		cmd.ins_step = (state_q == S_INS_STEP);
		cmd.ins_load = (state_q == S_INS_READ);
		cmd.ins_zero = (state_q == S_INS_ZERO);
		cmd.walk     = (state_q == S_WALK);
		cmd.fin      = (state_q == S_FIN) || ((state_q == S_WALK) && st.walk_end);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (st.func)
						hts_pkg::FUNC_INSERT: state_d = st.len_bad ? S_FIN : S_INS_STEP;
						hts_pkg::FUNC_DATA:   state_d = S_WALK;
						default:              state_d = S_FIN;
					endcase
				end
			end
			S_INS_STEP: begin
				unique case (st.ins_outcome)
					hts_pkg::INS_READ:  state_d = S_INS_READ;
					hts_pkg::INS_ALLOC: state_d = S_INS_ZERO;
					default:            state_d = S_FIN;
				endcase
			end
			S_INS_READ: state_d = S_INS_STEP;
			S_INS_ZERO: state_d = S_INS_STEP;
			S_WALK: begin
				if (st.walk_end && st.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: design/hts_datapath.sv
// Datapath of the decoder: node table, insert and walk logic, result registers.
// Depends on hts_pkg and hts_ram.
module hts_datapath #(
	parameter int NODE_COUNT = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hts_pkg::ctl_cmd_t   cmd,
	output hts_pkg::dp_status_t st,
	input  logic [1:0]          in_func,
	input  logic [7:0]          in_code_symbol,
	input  logic [5:0]          in_code_length,
	input  logic [31:0]         in_code_bits,
	input  logic [7:0]          in_data_byte,
	input  logic                cfg_wr_en,
	input  logic [47:0]         cfg_wr_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hts_pkg::res_t       out_res
);
	localparam int IW  = $clog2(NODE_COUNT);
	localparam int NFW = $clog2(NODE_COUNT + 1);
	// Entry layout: symbol, left valid, right valid, left link, right link.
	localparam int H0  = 8;
	localparam int H1  = 9;
	localparam int C0  = 10;
	localparam int C1  = 10 + IW;
	localparam int EW  = 10 + 2 * IW;

	hts_pkg::func_t func;
	logic           len_bad;

	logic [47:0]    sc_q, cnt_q, cnt_inc;
	logic           done_now, done_inc, done_after;
	logic [EW-1:0]  root_q;
	logic [NFW-1:0] nfn_q;
	logic [IW-1:0]  walk_q;
	logic           pend_q;
	logic [3:0]     bit_q;
	logic [7:0]     byte_q;

	logic [IW-1:0]  ins_node_q;
	logic [EW-1:0]  ins_ent_q;
	logic [5:0]     pos_q;
	logic [31:0]    bits_q;
	logic [7:0]     ins_sym_q;

	logic           hold_v_q;
	hts_pkg::res_t  hold_q;
	logic           out_valid_q;
	hts_pkg::res_t  out_q;

	logic           ram_we, ram_re;
	logic [IW-1:0]  ram_waddr, ram_raddr;
	logic [EW-1:0]  ram_wdata, ram_rdata;

	hts_ram #(
		.WIDTH(EW),
		.DEPTH(NODE_COUNT)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign func    = hts_pkg::func_t'(in_func);
	assign len_bad = (in_code_length == 6'd0) ||
		(in_code_length > 6'(hts_pkg::MAX_CODE_BITS));

	assign cnt_inc  = cnt_q + 48'd1;
	assign done_now = (cnt_q >= sc_q);
	assign done_inc = (cnt_inc >= sc_q);

	// Insert step on the entry of the current insert node.
	logic [EW-1:0]     ins_e, ins_linked, ins_symset, ins_wdata;
	logic              ins_pos_zero, ins_b, ins_has, ins_full, ins_any, ins_wr;
	logic [IW-1:0]     ins_child, new_idx;
	hts_pkg::ins_out_t ins_outcome;
	hts_pkg::status_t  ins_status;

	always_comb begin
		ins_e        = (ins_node_q == '0) ? root_q : ins_ent_q;
		ins_pos_zero = (pos_q == 6'd0);
		ins_b        = bits_q[5'(pos_q - 6'd1)];
		ins_has      = ins_b ? ins_e[H1] : ins_e[H0];
		ins_child    = ins_b ? ins_e[C1 +: IW] : ins_e[C0 +: IW];
		ins_any      = ins_e[H0] || ins_e[H1];
		ins_full     = (nfn_q >= NFW'(NODE_COUNT));
		new_idx      = IW'(nfn_q);
		ins_linked   = ins_e;
		if (ins_b) begin
			ins_linked[C1 +: IW] = new_idx;
			ins_linked[H1]       = 1'b1;
		end else begin
			ins_linked[C0 +: IW] = new_idx;
			ins_linked[H0]       = 1'b1;
		end
		ins_symset       = ins_e;
		ins_symset[7:0]  = ins_sym_q;
		ins_wdata        = ins_pos_zero ? ins_symset : ins_linked;
		if (ins_pos_zero) begin
			ins_outcome = hts_pkg::INS_DONE;
			ins_status  = ins_any ? hts_pkg::ST_CONFLICT : hts_pkg::ST_OK;
			ins_wr      = !ins_any;
		end else if (ins_has) begin
			ins_outcome = hts_pkg::INS_READ;
			ins_status  = hts_pkg::ST_OK;
			ins_wr      = 1'b0;
		end else if (ins_full) begin
			ins_outcome = hts_pkg::INS_DONE;
			ins_status  = hts_pkg::ST_FULL;
			ins_wr      = 1'b0;
		end else begin
			ins_outcome = hts_pkg::INS_ALLOC;
			ins_status  = hts_pkg::ST_OK;
			ins_wr      = 1'b1;
		end
	end

	// Walk step. A pending child read (issued at accept or by the previous bit) is checked for a leaf while the
	// next bit already moves on from the child or, after a leaf, from the root.
	logic [EW-1:0] walk_e;
	logic          a_leaf, b_act, bsel, b_has, b_miss, skip, b_do, produce, stall;
	logic          walk_end, out_free, walk_push, fin_push, push;
	logic [IW-1:0] b_child;
	hts_pkg::res_t walk_res, push_res;

	always_comb begin
		a_leaf     = pend_q && !ram_rdata[H0] && !ram_rdata[H1];
		walk_e     = (pend_q && !a_leaf) ? ram_rdata : root_q;
		done_after = a_leaf ? done_inc : done_now;
		b_act      = !bit_q[3] && !done_after;
		bsel       = byte_q[~bit_q[2:0]];
		b_has      = bsel ? walk_e[H1] : walk_e[H0];
		b_child    = bsel ? walk_e[C1 +: IW] : walk_e[C0 +: IW];
		b_miss     = b_act && !b_has;
		// Two results cannot leave in one cycle; the missing branch waits.
		skip       = a_leaf && b_miss;
		b_do       = b_act && !skip;
		produce    = a_leaf || (b_do && b_miss);
		walk_end   = !pend_q && !b_act;
		out_free   = !out_valid_q || out_ready;
		stall      = produce && hold_v_q && !out_free;

		walk_res.symbol     = a_leaf ? ram_rdata[7:0] : 8'd0;
		walk_res.has_symbol = a_leaf;
		walk_res.last       = 1'b0;
		walk_res.finished   = done_after;
		walk_res.status     = a_leaf ? hts_pkg::ST_OK : hts_pkg::ST_MISSING;

		walk_push = cmd.walk && produce && hold_v_q && !stall;
		fin_push  = cmd.fin && out_free;
		push      = walk_push || fin_push;

		if (walk_push) begin
			push_res      = hold_q;
			push_res.last = 1'b0;
		end else if (hold_v_q) begin
			push_res      = hold_q;
			push_res.last = 1'b1;
		end else begin
			push_res.symbol     = 8'd0;
			push_res.has_symbol = 1'b0;
			push_res.last       = 1'b1;
			push_res.finished   = done_now;
			push_res.status     = hts_pkg::ST_OK;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ins_node_q;
		ram_wdata = ins_wdata;
		ram_re    = 1'b0;
		ram_raddr = walk_q;
		if (cmd.ins_step && ins_wr && (ins_node_q != '0)) begin
			ram_we = 1'b1;
		end
		if (cmd.ins_zero) begin
			ram_we    = 1'b1;
			ram_wdata = '0;
		end
		if (cmd.accept && (func == hts_pkg::FUNC_DATA) && (walk_q != '0)) begin
			ram_re = 1'b1;
		end
		if (cmd.ins_step && (ins_outcome == hts_pkg::INS_READ)) begin
			ram_re    = 1'b1;
			ram_raddr = ins_child;
		end
		if (cmd.walk && !stall && b_do && !b_miss) begin
			ram_re    = 1'b1;
			ram_raddr = b_child;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= '0;
			cnt_q       <= '0;
			root_q      <= '0;
			nfn_q       <= NFW'(1);
			walk_q      <= '0;
			pend_q      <= 1'b0;
			bit_q       <= '0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sc_q <= cfg_wr_data;
			end
			if (fin_push) begin
				hold_v_q <= 1'b0;
			end
			if (cmd.accept) begin
				unique case (func)
					hts_pkg::FUNC_CLEAR: begin
						root_q   <= '0;
						nfn_q    <= NFW'(1);
						walk_q   <= '0;
						cnt_q    <= '0;
						hold_v_q <= 1'b1;
					end
					hts_pkg::FUNC_INSERT: begin
						if (len_bad) begin
							hold_v_q <= 1'b1;
						end
					end
					hts_pkg::FUNC_DATA: begin
						bit_q  <= '0;
						pend_q <= (walk_q != '0);
					end
					default: hold_v_q <= 1'b1;
				endcase
			end
			if (cmd.ins_step) begin
				if (ins_wr && (ins_node_q == '0)) begin
					root_q <= ins_wdata;
				end
				if (ins_outcome == hts_pkg::INS_ALLOC) begin
					nfn_q <= nfn_q + NFW'(1);
				end
				if (ins_outcome == hts_pkg::INS_DONE) begin
					hold_v_q <= 1'b1;
				end
			end
			if (cmd.walk && !stall) begin
				if (a_leaf) begin
					cnt_q <= cnt_inc;
				end
				if (b_do) begin
					bit_q  <= bit_q + 4'd1;
					walk_q <= b_miss ? '0 : b_child;
				end else if (a_leaf) begin
					walk_q <= '0;
				end
				pend_q <= b_do && !b_miss;
				if (produce) begin
					hold_v_q <= 1'b1;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q     <= in_data_byte;
			pos_q      <= in_code_length;
			bits_q     <= in_code_bits;
			ins_sym_q  <= in_code_symbol;
			ins_node_q <= '0;
			hold_q.symbol     <= 8'd0;
			hold_q.has_symbol <= 1'b0;
			hold_q.last       <= 1'b0;
			hold_q.finished   <= (func == hts_pkg::FUNC_CLEAR) ? (sc_q == 48'd0) : done_now;
			hold_q.status     <= ((func == hts_pkg::FUNC_INSERT) && len_bad) ?
				hts_pkg::ST_CONFLICT : hts_pkg::ST_OK;
		end
		if (cmd.ins_step) begin
			unique case (ins_outcome)
				hts_pkg::INS_READ: begin
					ins_node_q <= ins_child;
					pos_q      <= pos_q - 6'd1;
				end
				hts_pkg::INS_ALLOC: begin
					ins_node_q <= new_idx;
					ins_ent_q  <= '0;
					pos_q      <= pos_q - 6'd1;
				end
				default: begin
					hold_q.symbol     <= 8'd0;
					hold_q.has_symbol <= 1'b0;
					hold_q.last       <= 1'b0;
					hold_q.finished   <= done_now;
					hold_q.status     <= ins_status;
				end
			endcase
		end
		if (cmd.ins_load) begin
			ins_ent_q <= ram_rdata;
		end
		if (cmd.walk && !stall && produce) begin
			hold_q <= walk_res;
		end
		if (push) begin
			out_q <= push_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_comb begin
		st.func        = func;
		st.len_bad     = len_bad;
		st.ins_outcome = ins_outcome;
		st.walk_end    = walk_end;
		st.out_free    = out_free;
	end
endmodule

FILE: design/huffman_tree_stream_decoder.sv
// Top level of the Huffman tree stream decoder: sequencer plus datapath.
// Depends on hts_pkg, hts_stream_if, hts_ram, hts_ctrl and hts_datapath.
//
//   channel   direction  handshake      content
//   items     in         valid/ready    func, code_symbol, code_length, code_bits, data_byte
//   results   out        valid/ready    symbol, has_symbol, last, finished, status
//   cfg       in         cfg_wr_en      cfg_wr_data: symbol_count, 48 bits
//
// A data byte is walked one bit per cycle, set by the dependent node table read through the
// RAM's registered port, unless the result side stalls or a leaf and a missing branch meet,
// when the missing branch waits. The item closes once the child read of its last bit is
// checked; it closes early once symbol_count is reached. An insert steps through the code
// bits, reading each existing child or zeroing a newly allocated entry; a clear goes straight
// to the closing state. Reset empties the tree root in flip-flops at once; other table entries
// are written when allocated. A stalled result side holds the walk while the next item still
// transfers once the output register has taken the final result.
module huffman_tree_stream_decoder #(
	parameter int NODE_COUNT = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	hts_in_if.sink        items,
	hts_out_if.source     results,
	input  logic          cfg_wr_en,
	input  logic [47:0]   cfg_wr_data
);
	hts_pkg::ctl_cmd_t   cmd;
	hts_pkg::dp_status_t st;
	hts_pkg::res_t       res;

	hts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(items.valid),
		.in_ready(items.ready),
		.st      (st),
		.cmd     (cmd)
	);

	hts_datapath #(
		.NODE_COUNT(NODE_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.in_func       (items.func),
		.in_code_symbol(items.code_symbol),
		.in_code_length(items.code_length),
		.in_code_bits  (items.code_bits),
		.in_data_byte  (items.data_byte),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_res       (res)
	);

	assign results.symbol     = res.symbol;
	assign results.has_symbol = res.has_symbol;
	assign results.last       = res.last;
	assign results.finished   = res.finished;
	assign results.status     = res.status;
endmodule
